// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also checks during reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/pram_pkg.sv =====
// ----------------------------------------------------------------------------
// pram_pkg
// Types and constants shared by the PRAM / clock command unit.
// ----------------------------------------------------------------------------
package pram_pkg;

   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int QUEUE_DEPTH = 2;

   // operation kinds
   localparam logic [1:0] OP_ECHO  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // read overrides
   localparam logic [1:0] OVR_NONE  = 2'd0;
   localparam logic [1:0] OVR_MASK  = 2'd1;
   localparam logic [1:0] OVR_SET05 = 2'd2;
   localparam logic [1:0] OVR_LT    = 2'd3;

   localparam logic [ADDR_W-1:0] ADDR_MASKED = 8'h08;
   localparam logic [ADDR_W-1:0] ADDR_FLAGS  = 8'h8a;
   localparam logic [ADDR_W-1:0] ADDR_LT0    = 8'he0;
   localparam logic [ADDR_W-1:0] ADDR_LT1    = 8'he1;
   localparam logic [ADDR_W-1:0] ADDR_LT2    = 8'he2;
   localparam logic [ADDR_W-1:0] ADDR_LT3    = 8'he3;

   localparam logic [7:0] READ_MASK  = 8'hf8;
   localparam logic [7:0] FORCE_BITS = 8'h05;
   localparam logic [7:0] LT_VAL0    = 8'h00;
   localparam logic [7:0] LT_VAL1    = 8'hf1;
   localparam logic [7:0] LT_VAL2    = 8'h00;
   localparam logic [7:0] LT_VAL3    = 8'h0a;

   // csr register indexes
   localparam logic REG_ROM_CLEAN = 1'b0;
   localparam logic REG_ADDR24    = 1'b1;

   typedef struct packed {
      logic rom_is_32bit_clean;
      logic addr24_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        ovr;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } op_type;

endpackage

// ===== hdl/pram_front.sv =====
// ----------------------------------------------------------------------------
// pram_front
// Decodes a command item into a store read, write or echo operation with its read override.
// ----------------------------------------------------------------------------
module pram_front (
   input  pram_pkg::cfg_type cfg,
   input  logic              mode,
   input  logic [15:0]       command,
   input  logic [7:0]        data_in,
   input  logic [31:0]       time_now,
   input  logic [7:0]        direct_index,
   output pram_pkg::op_type  op
);
   import pram_pkg::*;

   logic              rd;
   logic              ext;
   logic [ADDR_W-1:0] ext_addr;
   logic [4:0]        cls_addr;
   logic              cls_store;
   logic [7:0]        time_byte;

   assign rd        = command[7];
   assign ext       = (command[6:3] == 4'b0111);
   assign ext_addr  = {command[2:0], command[14:10]};
   assign cls_addr  = command[6:2];
   assign cls_store = cls_addr[4] || (cls_addr[4:2] == 3'b010);

   always_comb begin
      case (cls_addr[1:0])
         2'd0:    time_byte = time_now[7:0];
         2'd1:    time_byte = time_now[15:8];
         2'd2:    time_byte = time_now[23:16];
         default: time_byte = time_now[31:24];
      endcase
   end

   always_comb begin
      op.kind = OP_ECHO;
      op.ovr  = OVR_NONE;
      op.addr = ext_addr;
      op.data = data_in;
      if (mode) begin
         op.kind = OP_READ;
         op.addr = direct_index;
      end else if (ext) begin
         if (rd) begin
            op.kind = OP_READ;
            if (ext_addr == ADDR_MASKED && !cfg.rom_is_32bit_clean) begin
               op.ovr = OVR_MASK;
            end else if (ext_addr == ADDR_FLAGS) begin
               op.ovr = OVR_SET05;
            end else if (ext_addr inside {[ADDR_LT0:ADDR_LT3]}) begin
               op.ovr = OVR_LT;
               case (ext_addr[1:0])
                  2'd0:    op.data = LT_VAL0;
                  2'd1:    op.data = LT_VAL1;
                  2'd2:    op.data = LT_VAL2;
                  default: op.data = LT_VAL3;
               endcase
            end
         end else begin
            op.kind = OP_WRITE;
            if (ext_addr == ADDR_FLAGS && !cfg.addr24_mode) begin
               op.data = data_in | FORCE_BITS;
            end
         end
      end else begin
         op.addr = {{(ADDR_W-5){1'b0}}, cls_addr};
         if (cls_store) begin
            op.kind = rd ? OP_READ : OP_WRITE;
         end else if (!cls_addr[3] && rd) begin
            op.data = time_byte;
         end
      end
   end

endmodule

// ===== hdl/pram_queue.sv =====
// ----------------------------------------------------------------------------
// pram_queue
// Short FIFO of decoded operations between front and back.
// ----------------------------------------------------------------------------
module pram_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pram_pkg::op_type push_op,
   input  logic             pop,
   output pram_pkg::op_type head_op,
   output logic             full,
   output logic             empty
);
   import pram_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   op_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== hdl/pram_back.sv =====
// ----------------------------------------------------------------------------
// pram_back
// Executes operations against the parameter store and holds the result.
// ----------------------------------------------------------------------------
module pram_back (
   input  logic             clock,
   input  logic             reset,
   input  pram_pkg::op_type head_op,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_data
);
   import pram_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RD   = 1'b1;

   logic [7:0]             mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] valid_ff, valid_in;
   logic [7:0]             rd_data_ff;
   logic                   rd_valid_ff;
   op_type                 op_ff;
   logic [7:0]             lt0_ff, lt0_in;
   logic [7:0]             lt1_ff, lt1_in;
   logic                   state_ff, state_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_data_ff, out_data_in;
   logic                   out_free, take, mem_we, load_now, load_rd, lt;
   logic [7:0]             base, rd_result;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign take      = (state_ff == ST_IDLE) && !q_empty && out_free;
   assign q_pop     = take;
   assign mem_we    = take && (head_op.kind == OP_WRITE);
   assign load_now  = take && (head_op.kind != OP_READ);
   assign load_rd   = (state_ff == ST_RD);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign lt        = (lt0_ff == 8'h00) && (lt1_ff == 8'h00);
   assign base      = rd_valid_ff ? rd_data_ff : 8'h00;

   always_comb begin
      case (op_ff.ovr)
         OVR_MASK:  rd_result = base & READ_MASK;
         OVR_SET05: rd_result = base | FORCE_BITS;
         OVR_LT:    rd_result = lt ? op_ff.data : base;
         default:   rd_result = base;
      endcase
   end

   always_comb begin
      state_in = ST_IDLE;
      if (take && head_op.kind == OP_READ) begin
         state_in = ST_RD;
      end
      valid_in = valid_ff;
      lt0_in   = lt0_ff;
      lt1_in   = lt1_ff;
      if (mem_we) begin
         valid_in[head_op.addr] = 1'b1;
         if (head_op.addr == ADDR_LT0) begin
            lt0_in = head_op.data;
         end
         if (head_op.addr == ADDR_LT1) begin
            lt1_in = head_op.data;
         end
      end
      out_valid_in = load_now || load_rd || (out_valid_ff && !rsp_pop);
      out_data_in  = out_data_ff;
      if (load_rd) begin
         out_data_in = rd_result;
      end else if (load_now) begin
         out_data_in = head_op.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         lt0_ff       <= 8'h00;
         lt1_ff       <= 8'h00;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         lt0_ff       <= lt0_in;
         lt1_ff       <= lt1_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (take) begin
         op_ff       <= head_op;
         rd_valid_ff <= valid_ff[head_op.addr];
      end
   end

   // store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[head_op.addr] <= head_op.data;
      end
      if (take) begin
         rd_data_ff <= mem[head_op.addr];
      end
   end

endmodule

// ===== hdl/pram_rtc_command_unit.sv =====
// ----------------------------------------------------------------------------
// pram_rtc_command_unit
// Parameter RAM and clock command decoder with an APB-style control port.
// ----------------------------------------------------------------------------
// A write or echo item passes the queue slot, then the result register; a
// store read also passes the registered store read. Writes and echoes go at
// one item per cycle while results are taken; a read stalls the next item.
// Reset clears the queue, the result register, the controls and all 256 store
// valid bits at once, so the store reads as zero with no clearing pass.
// ----------------------------------------------------------------------------
module pram_rtc_command_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_mode,
   input  logic [15:0] req_command,
   input  logic [7:0]  req_data_in,
   input  logic [31:0] req_time_now,
   input  logic [7:0]  req_direct_index,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_data_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pram_pkg::*;

   cfg_type cfg_ff, cfg_in;
   op_type  front_op, head_op;
   logic    q_empty, q_pop, csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (paddr[2])
            REG_ROM_CLEAN: cfg_in.rom_is_32bit_clean = pwdata[0];
            REG_ADDR24:    cfg_in.addr24_mode        = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
      case (paddr[2])
         REG_ROM_CLEAN: prdata = {31'b0, cfg_ff.rom_is_32bit_clean};
         REG_ADDR24:    prdata = {31'b0, cfg_ff.addr24_mode};
         default:       prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pram_front u_front (
      .cfg          (cfg_ff),
      .mode         (req_mode),
      .command      (req_command),
      .data_in      (req_data_in),
      .time_now     (req_time_now),
      .direct_index (req_direct_index),
      .op           (front_op)
   );

   pram_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (front_op),
      .pop     (q_pop),
      .head_op (head_op),
      .full    (full),
      .empty   (q_empty)
   );

   pram_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_op   (head_op),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_data  (rsp_data_out)
   );

endmodule

// ===== hdl/pram_checker.sv =====
// ----------------------------------------------------------------------------
// pram_checker
// Port-level checks for the PRAM / clock command unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pram_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [7:0]  rsp_data_out,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [2:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);

   logic wr;

   assign wr = psel && penable && pwrite && pready;

   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, empty && !full)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_data_out))

   `ASSERT_NEXT(a_cfg_readback, clock, reset, wr, prdata[0] == $past(pwdata[0]) || $changed(paddr))

   `ASSERT_NOW(a_prdata_narrow, clock, reset, pready, prdata[31:1] == 31'b0)

endmodule

bind pram_rtc_command_unit pram_checker u_checker (.*);
